// File: rtl/core/sjfs_pkg.sv
package sjfs_pkg;

   localparam int MAX_PROCS_DEF = 32;
   localparam int QUEUE_DEPTH   = 4;
   localparam int ID_W          = 16;
   localparam int TIME_W        = 16;
   localparam int CLK_W         = 22;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // register index is paddr[2]
   localparam logic REG_PREEMPT = 1'b0;

   typedef struct packed {
      logic [ID_W-1:0]   proc_id;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic              last_proc;
   } item_type;

   typedef enum logic [2:0] {
      B_LOAD,
      B_CHECK,
      B_SCAN,
      B_EXEC,
      B_EMIT_RD,
      B_EMIT_DATA,
      B_EMIT_OUT
   } back_state_type;

endpackage

// File: rtl/core/sjfs_front.sv
module sjfs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sjfs_pkg::ID_W-1:0]        req_proc_id,
   input  logic [sjfs_pkg::TIME_W-1:0]      req_arrival,
   input  logic [sjfs_pkg::TIME_W-1:0]      req_burst,
   input  logic                             req_last_proc,
   input  logic                             q_full,
   output logic                             q_push,
   output sjfs_pkg::item_type               q_item
);
   import sjfs_pkg::*;

   item_type item_ff, item_in;
   logic     vld_ff, vld_in;
   logic     accept;

   assign req_stall = vld_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = vld_ff & ~q_full;
   assign q_item    = item_ff;

   always_comb begin
      item_in           = item_ff;
      vld_in            = vld_ff;
      if (q_push) begin
         vld_in = 1'b0;
      end
      if (accept) begin
         vld_in            = 1'b1;
         item_in.proc_id   = req_proc_id;
         item_in.arrival   = req_arrival;
         // zero burst runs as one unit
         item_in.burst     = (req_burst == '0) ? TIME_W'(1) : req_burst;
         item_in.last_proc = req_last_proc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

endmodule

// File: rtl/core/sjfs_queue.sv
module sjfs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sjfs_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output sjfs_pkg::item_type head_item
);
   import sjfs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == DEPTH_CNT);
   assign empty     = (cnt_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/sjfs_back.sv
module sjfs_back #(
   parameter int MAX_PROCS = sjfs_pkg::MAX_PROCS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          preempt_mode,
   input  logic                          q_empty,
   input  sjfs_pkg::item_type            q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sjfs_pkg::ID_W-1:0]     rsp_out_id,
   output logic [sjfs_pkg::CLK_W-1:0]    rsp_completion,
   output logic [sjfs_pkg::CLK_W-1:0]    rsp_turnaround,
   output logic [sjfs_pkg::CLK_W-1:0]    rsp_waiting,
   output logic [sjfs_pkg::CLK_W-1:0]    rsp_response,
   output logic                          rsp_last_result
);
   import sjfs_pkg::*;

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int EXT_W = CLK_W - TIME_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCS);

   back_state_type state_ff, state_in;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     done_ff, done_in;
   logic [CNT_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic [CLK_W-1:0]     sim_clock_ff, sim_clock_in;
   logic [MAX_PROCS-1:0] fin_flags_ff, fin_flags_in;
   logic [MAX_PROCS-1:0] start_flags_ff, start_flags_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [TIME_W:0]      best_rem_ff, best_rem_in;
   logic                 pick_vld_ff, pick_vld_in;
   logic [IDX_W-1:0]     pick_idx_ff, pick_idx_in;
   logic                 na_vld_ff, na_vld_in;
   logic [TIME_W-1:0]    na_ff, na_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [CLK_W-1:0]     rsp_comp_ff, rsp_comp_in;
   logic [CLK_W-1:0]     rsp_tat_ff, rsp_tat_in;
   logic [CLK_W-1:0]     rsp_wait_ff, rsp_wait_in;
   logic [CLK_W-1:0]     rsp_resp_ff, rsp_resp_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [ID_W-1:0]      id_mem  [MAX_PROCS];
   logic [TIME_W-1:0]    arr_mem [MAX_PROCS];
   logic [TIME_W-1:0]    bur_mem [MAX_PROCS];
   logic [TIME_W-1:0]    rem_mem [MAX_PROCS];
   logic [CLK_W-1:0]     fin_mem [MAX_PROCS];
   logic [CLK_W-1:0]     fst_mem [MAX_PROCS];

   logic [ID_W-1:0]      id_rd;
   logic [TIME_W-1:0]    arr_rd, bur_rd, rem_rd;
   logic [CLK_W-1:0]     fin_rd, fst_rd;

   logic                 load_we, rem_we, fin_we, fst_we;
   logic [IDX_W-1:0]     rd_addr;
   logic [CLK_W-1:0]     arr_ext, na_ext, gap, clock_after;
   logic [TIME_W-1:0]    run, left;
   logic [CLK_W-1:0]     tat;
   logic                 cut;

   // execute-step arithmetic
   assign na_ext      = {{EXT_W{1'b0}}, na_ff};
   assign gap         = na_ext - sim_clock_ff;
   assign cut         = preempt_mode & na_vld_ff &
                        (gap < {{EXT_W{1'b0}}, best_rem_ff[TIME_W-1:0]});
   assign run         = cut ? gap[TIME_W-1:0] : best_rem_ff[TIME_W-1:0];
   assign left        = best_rem_ff[TIME_W-1:0] - run;
   assign clock_after = sim_clock_ff + {{EXT_W{1'b0}}, run};

   assign arr_ext     = {{EXT_W{1'b0}}, arr_rd};
   assign tat         = fin_rd - arr_ext;

   assign rd_addr = (state_ff == B_SCAN) ? scan_cnt_ff[IDX_W-1:0] : emit_cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_LOAD: begin
            if (!q_empty && q_item.last_proc) begin
               state_in = B_CHECK;
            end
         end
         B_CHECK: begin
            if (done_ff != count_ff) begin
               state_in = B_SCAN;
            end else if (count_ff == '0) begin
               state_in = B_LOAD;
            end else begin
               state_in = B_EMIT_RD;
            end
         end
         B_SCAN: begin
            if (scan_cnt_ff >= count_ff && !pend_ff) begin
               state_in = B_EXEC;
            end
         end
         B_EXEC:      state_in = B_CHECK;
         B_EMIT_RD:   state_in = B_EMIT_DATA;
         B_EMIT_DATA: state_in = B_EMIT_OUT;
         B_EMIT_OUT: begin
            if (!rsp_stall) begin
               state_in = rsp_last_ff ? B_LOAD : B_EMIT_RD;
            end
         end
         default:     state_in = B_LOAD;
      endcase
   end

   always_comb begin
      q_pop          = 1'b0;
      load_we        = 1'b0;
      rem_we         = 1'b0;
      fin_we         = 1'b0;
      fst_we         = 1'b0;
      count_in       = count_ff;
      done_in        = done_ff;
      scan_cnt_in    = scan_cnt_ff;
      emit_cnt_in    = emit_cnt_ff;
      sim_clock_in   = sim_clock_ff;
      fin_flags_in   = fin_flags_ff;
      start_flags_in = start_flags_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      best_rem_in    = best_rem_ff;
      pick_vld_in    = pick_vld_ff;
      pick_idx_in    = pick_idx_ff;
      na_vld_in      = na_vld_ff;
      na_in          = na_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_comp_in    = rsp_comp_ff;
      rsp_tat_in     = rsp_tat_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_resp_in    = rsp_resp_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         B_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (count_ff < MAX_CNT) begin
                  load_we  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         B_CHECK: begin
            if (done_ff != count_ff) begin
               scan_cnt_in = '0;
               pend_in     = 1'b0;
               best_rem_in = {1'b1, {TIME_W{1'b0}}};
               pick_vld_in = 1'b0;
               na_vld_in   = 1'b0;
            end else if (count_ff == '0) begin
               sim_clock_in = '0;
               done_in      = '0;
            end else begin
               emit_cnt_in = '0;
            end
         end
         B_SCAN: begin
            if (scan_cnt_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_cnt_ff[IDX_W-1:0];
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && !fin_flags_ff[pend_idx_ff]) begin
               if (arr_ext <= sim_clock_ff) begin
                  if ({1'b0, rem_rd} < best_rem_ff) begin
                     best_rem_in = {1'b0, rem_rd};
                     pick_vld_in = 1'b1;
                     pick_idx_in = pend_idx_ff;
                  end
               end else if (!na_vld_ff || arr_rd < na_ff) begin
                  na_vld_in = 1'b1;
                  na_in     = arr_rd;
               end
            end
         end
         B_EXEC: begin
            if (pick_vld_ff) begin
               rem_we       = 1'b1;
               sim_clock_in = clock_after;
               if (!start_flags_ff[pick_idx_ff]) begin
                  fst_we                      = 1'b1;
                  start_flags_in[pick_idx_ff] = 1'b1;
               end
               if (left == '0) begin
                  fin_we                    = 1'b1;
                  fin_flags_in[pick_idx_ff] = 1'b1;
                  done_in                   = done_ff + CNT_W'(1);
               end
            end else begin
               sim_clock_in = na_ext;
            end
         end
         B_EMIT_RD: begin
         end
         B_EMIT_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = id_rd;
            rsp_comp_in  = fin_rd;
            rsp_tat_in   = tat;
            rsp_wait_in  = tat - {{EXT_W{1'b0}}, bur_rd};
            rsp_resp_in  = fst_rd - arr_ext;
            rsp_last_in  = (emit_cnt_ff + CNT_W'(1) == count_ff);
         end
         B_EMIT_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               emit_cnt_in  = emit_cnt_ff + CNT_W'(1);
               if (rsp_last_ff) begin
                  count_in       = '0;
                  done_in        = '0;
                  sim_clock_in   = '0;
                  fin_flags_in   = '0;
                  start_flags_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_LOAD;
         count_ff       <= '0;
         done_ff        <= '0;
         sim_clock_ff   <= '0;
         fin_flags_ff   <= '0;
         start_flags_ff <= '0;
         pend_ff        <= 1'b0;
         pick_vld_ff    <= 1'b0;
         na_vld_ff      <= 1'b0;
         scan_cnt_ff    <= '0;
         emit_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         done_ff        <= done_in;
         sim_clock_ff   <= sim_clock_in;
         fin_flags_ff   <= fin_flags_in;
         start_flags_ff <= start_flags_in;
         pend_ff        <= pend_in;
         pick_vld_ff    <= pick_vld_in;
         na_vld_ff      <= na_vld_in;
         scan_cnt_ff    <= scan_cnt_in;
         emit_cnt_ff    <= emit_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
      best_rem_ff <= best_rem_in;
      pick_idx_ff <= pick_idx_in;
      na_ff       <= na_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_tat_ff  <= rsp_tat_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_resp_ff <= rsp_resp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // process tables
   always_ff @(posedge clock) begin
      if (load_we) begin
         id_mem[count_ff[IDX_W-1:0]]  <= q_item.proc_id;
         arr_mem[count_ff[IDX_W-1:0]] <= q_item.arrival;
         bur_mem[count_ff[IDX_W-1:0]] <= q_item.burst;
      end
      if (load_we) begin
         rem_mem[count_ff[IDX_W-1:0]] <= q_item.burst;
      end else if (rem_we) begin
         rem_mem[pick_idx_ff] <= left;
      end
      if (fin_we) begin
         fin_mem[pick_idx_ff] <= clock_after;
      end
      if (fst_we) begin
         fst_mem[pick_idx_ff] <= sim_clock_ff;
      end
      id_rd  <= id_mem[rd_addr];
      arr_rd <= arr_mem[rd_addr];
      bur_rd <= bur_mem[rd_addr];
      rem_rd <= rem_mem[rd_addr];
      fin_rd <= fin_mem[rd_addr];
      fst_rd <= fst_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_completion  = rsp_comp_ff;
   assign rsp_turnaround  = rsp_tat_ff;
   assign rsp_waiting     = rsp_wait_ff;
   assign rsp_response    = rsp_resp_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

// File: rtl/core/shortest_job_first_scheduler_core.sv
// Shortest-job-first scheduler. Processes are loaded one transaction per
// cycle while req_stall is low on the req_ channel (id, arrival, burst,
// last_proc); a zero burst counts as one unit and entries beyond
// MAX_PROCS are dropped. The transaction with last_proc set starts the
// schedule run, non-preemptive or shortest-remaining-time as set by csr
// register 0 (APB, address 0, bit 0). Loading passes through an input
// register and a 4-entry queue, so req_stall only rises when the queue is
// full, e.g. while a run or result phase is on. Each scheduling step scans
// the loaded table through one memory read port; a run takes at most about
// 2n steps for n processes. Results then leave in load order on the rsp_
// channel, one at a time; the result register holds while rsp_stall is high,
// and rsp_last_result marks the final one. After it the tables are free for
// the next set. Reset (synchronous) empties the queue, clears the set and
// sets the mode to non-preemptive; no memory clearing pass is needed.
module shortest_job_first_scheduler_core #(
   parameter int MAX_PROCS = sjfs_pkg::MAX_PROCS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sjfs_pkg::ID_W-1:0]        req_proc_id,
   input  logic [sjfs_pkg::TIME_W-1:0]      req_arrival,
   input  logic [sjfs_pkg::TIME_W-1:0]      req_burst,
   input  logic                             req_last_proc,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sjfs_pkg::ID_W-1:0]        rsp_out_id,
   output logic [sjfs_pkg::CLK_W-1:0]       rsp_completion,
   output logic [sjfs_pkg::CLK_W-1:0]       rsp_turnaround,
   output logic [sjfs_pkg::CLK_W-1:0]       rsp_waiting,
   output logic [sjfs_pkg::CLK_W-1:0]       rsp_response,
   output logic                             rsp_last_result,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sjfs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sjfs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sjfs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import sjfs_pkg::*;

   logic     preempt_ff, preempt_in;
   logic     reg_sel;
   logic     q_full, q_empty, q_push, q_pop;
   item_type front_item, head_item;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[2] == REG_PREEMPT);
   assign csr_prdata = reg_sel ? {{(CSR_DATA_W-1){1'b0}}, preempt_ff} : '0;

   always_comb begin
      preempt_in = preempt_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         preempt_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preempt_ff <= 1'b0;
      end else begin
         preempt_ff <= preempt_in;
      end
   end

   sjfs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_proc_id   (req_proc_id),
      .req_arrival   (req_arrival),
      .req_burst     (req_burst),
      .req_last_proc (req_last_proc),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (front_item)
   );

   sjfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_item (head_item)
   );

   sjfs_back #(
      .MAX_PROCS (MAX_PROCS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .preempt_mode    (preempt_ff),
      .q_empty         (q_empty),
      .q_item          (head_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_id      (rsp_out_id),
      .rsp_completion  (rsp_completion),
      .rsp_turnaround  (rsp_turnaround),
      .rsp_waiting     (rsp_waiting),
      .rsp_response    (rsp_response),
      .rsp_last_result (rsp_last_result)
   );

endmodule
